/* design/hts_pkg.sv */
`default_nettype none

package hts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_ADD       = 3'd1;
  localparam logic [2:0] CMD_DELETE    = 3'd2;
  localparam logic [2:0] CMD_ENABLE    = 3'd3;
  localparam logic [2:0] CMD_DISABLE   = 3'd4;
  localparam logic [2:0] CMD_ADD_DELAY = 3'd5;
  localparam logic [2:0] CMD_DISPATCH  = 3'd6;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_PRE    = 2'd1;
  localparam logic [1:0] KIND_COOP   = 2'd2;
  localparam logic [1:0] KIND_HANDLE = 2'd3;

  typedef struct packed {
    logic [7:0]  tid;
    logic        valid;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
    logic        coop;
    logic        enabled;
  } slot_t;

  localparam slot_t SLOT_RESET = '{
    tid: 8'd0, valid: 1'b0, delay: 32'd0, period: 32'd0,
    pending: 8'd0, coop: 1'b1, enabled: 1'b0
  };

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot_index;
    logic [7:0] run_task_id;
    logic       table_full;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EDIT,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

/* design/hybrid_tick_task_scheduler.sv */
// task slot scheduler
// input channel: one command per item (tick, add, delete, enable, disable,
// add delay, dispatch) with its slot, task id, delay, period and flags.
// result channel: one or more items per command, the final one with last set.
// tick and dispatch visit each slot in order through a slot table memory with
// registered reads; the read of the next slot overlaps the write-back of the
// current one. after the last slot a scan places its done item in the output
// register and then takes the next command. add writes its slot at the accept;
// delete, enable, disable and add delay read the slot and then write it back.
// the slot table has a single read port.
// one command is handled at a time; the next is accepted once the done or
// handle item has been placed in the output register, even if it is not yet
// taken. results leave through that register in the cycle after they are formed.
// when the output register is full and out_ready is low the scan holds on the
// slot that has a run event to report and resumes when the register frees.
// after reset every slot reads as empty, disabled and cooperative, and the
// next add uses slot 0; no clearing pass is needed.
`default_nettype none

module hybrid_tick_task_scheduler
  import hts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_slot,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [31:0] in_delay_value,
  input  wire logic [31:0] in_period,
  input  wire logic        in_cooperative,
  input  wire logic        in_enable_now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_slot_index,
  output logic [7:0]       out_run_task_id,
  output logic             out_table_full,
  output logic             out_last
);

  mem_req_t req;
  slot_t    rdata;
  logic     space;
  logic     emit;
  res_t     res;

  hts_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  hts_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_task_id     (in_task_id),
    .in_delay_value (in_delay_value),
    .in_period      (in_period),
    .in_cooperative (in_cooperative),
    .in_enable_now  (in_enable_now),
    .req            (req),
    .rdata          (rdata),
    .space          (space),
    .emit           (emit),
    .res            (res)
  );

  hts_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .emit            (emit),
    .res             (res),
    .space           (space),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_slot_index  (out_slot_index),
    .out_run_task_id (out_run_task_id),
    .out_table_full  (out_table_full),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

/* design/hts_mem.sv */
`default_nettype none

module hts_mem
  import hts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output slot_t         rdata
);

  slot_t                mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] init_r;
  slot_t                rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= init_r[req.rd_addr] ? mem[req.rd_addr] : SLOT_RESET;
    end
  end

  // entries read as reset value until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (req.wr_en) begin
      init_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/hts_out.sv */
`default_nettype none

module hts_out
  import hts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       emit,
  input  wire res_t       res,
  output logic            space,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_slot_index,
  output logic [7:0]      out_run_task_id,
  output logic            out_table_full,
  output logic            out_last
);

  logic valid_r;
  res_t res_r;

  assign space = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_slot_index  = res_r.slot_index;
  assign out_run_task_id = res_r.run_task_id;
  assign out_table_full  = res_r.table_full;
  assign out_last        = res_r.last;

endmodule

`default_nettype wire

/* design/hts_ctrl.sv */
`default_nettype none

module hts_ctrl
  import hts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_slot,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [31:0] in_delay_value,
  input  wire logic [31:0] in_period,
  input  wire logic        in_cooperative,
  input  wire logic        in_enable_now,
  output mem_req_t         req,
  input  wire slot_t       rdata,
  input  wire logic        space,
  output logic             emit,
  output res_t             res
);

  st_t              state_r, state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [2:0]       cmd_r;
  logic [2:0]       slot_r;
  logic [31:0]      dval_r;
  logic [2:0]       hnd_slot_r;
  logic             hnd_full_r;
  logic [CNT_W-1:0] next_free_r;

  logic             in_fire;
  logic             in_range;
  logic             is_scan_cmd;
  logic             is_edit_cmd;
  logic             has_free;
  logic             last_slot;
  logic             adv;
  slot_t            upd;
  logic             ev;
  logic [1:0]       ev_kind;
  logic [32:0]      dsum;

  assign in_fire     = in_valid && in_ready;
  assign in_range    = 32'(in_slot) < NUM_SLOTS;
  assign is_scan_cmd = (in_command == CMD_TICK) || (in_command == CMD_DISPATCH);
  assign is_edit_cmd = (in_command == CMD_DELETE) || (in_command == CMD_ENABLE) ||
                       (in_command == CMD_DISABLE) || (in_command == CMD_ADD_DELAY);
  assign has_free    = 32'(next_free_r) < NUM_SLOTS;
  assign last_slot   = 32'(idx_r) == NUM_SLOTS - 1;
  assign adv         = !ev || space;
  assign dsum        = {1'b0, rdata.delay} + {1'b0, dval_r};

  // per-slot update of the entry just read
  always_comb begin
    upd     = rdata;
    ev      = 1'b0;
    ev_kind = KIND_DONE;
    case (cmd_r)
      CMD_TICK: begin
        if (rdata.enabled) begin
          if (rdata.delay == 32'd0) begin
            if (rdata.coop) begin
              if (rdata.pending != 8'hFF) begin
                upd.pending = rdata.pending + 8'd1;
              end
            end else if (rdata.valid) begin
              ev      = 1'b1;
              ev_kind = KIND_PRE;
            end
            if (rdata.period != 32'd0) begin
              upd.delay = rdata.period - 32'd1;
            end
          end else begin
            upd.delay = rdata.delay - 32'd1;
          end
        end
      end
      CMD_DISPATCH: begin
        if (rdata.coop && rdata.pending != 8'd0) begin
          if (rdata.valid) begin
            ev      = 1'b1;
            ev_kind = KIND_COOP;
          end
          upd.pending = rdata.pending - 8'd1;
        end
        if (rdata.period == 32'd0) begin
          upd.valid = 1'b0;
        end
      end
      CMD_DELETE: begin
        upd.valid   = 1'b0;
        upd.delay   = 32'd0;
        upd.period  = 32'd0;
        upd.pending = 8'd0;
        upd.enabled = 1'b0;
      end
      CMD_ENABLE: begin
        upd.enabled = 1'b1;
      end
      CMD_DISABLE: begin
        upd.enabled = 1'b0;
        upd.delay   = 32'd0;
      end
      CMD_ADD_DELAY: begin
        upd.delay = dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_scan_cmd) begin
            state_nxt = ST_SCAN;
          end else if (is_edit_cmd && in_range) begin
            state_nxt = ST_EDIT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (adv && last_slot) begin
          state_nxt = ST_DONE;
        end
      end
      ST_EDIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (space) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    req      = '0;
    emit     = 1'b0;
    res      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (is_scan_cmd) begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
          end else if (is_edit_cmd && in_range) begin
            req.rd_en   = 1'b1;
            req.rd_addr = IDX_W'(in_slot);
          end else if (in_command == CMD_ADD && has_free) begin
            req.wr_en           = 1'b1;
            req.wr_addr         = IDX_W'(next_free_r);
            req.wr_data.tid     = in_task_id;
            req.wr_data.valid   = 1'b1;
            req.wr_data.delay   = in_delay_value;
            req.wr_data.period  = in_period;
            req.wr_data.pending = 8'd0;
            req.wr_data.coop    = in_cooperative;
            req.wr_data.enabled = in_enable_now;
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          req.wr_en   = 1'b1;
          req.wr_addr = idx_r;
          req.wr_data = upd;
          emit        = ev;
          res.kind        = ev_kind;
          res.slot_index  = 3'(idx_r);
          res.run_task_id = rdata.tid;
          if (!last_slot) begin
            req.rd_en   = 1'b1;
            req.rd_addr = idx_r + 1'b1;
          end
        end
      end
      ST_EDIT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = IDX_W'(slot_r);
        req.wr_data = upd;
      end
      ST_DONE: begin
        emit     = space;
        res.last = 1'b1;
        if (cmd_r == CMD_ADD) begin
          res.kind       = KIND_HANDLE;
          res.slot_index = hnd_slot_r;
          res.table_full = hnd_full_r;
        end else begin
          res.kind = KIND_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        idx_r <= '0;
        if (in_command == CMD_ADD && has_free) begin
          next_free_r <= next_free_r + 1'b1;
        end
      end else if (state_r == ST_SCAN && adv) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_command;
      slot_r     <= in_slot;
      dval_r     <= in_delay_value;
      hnd_slot_r <= has_free ? 3'(next_free_r) : 3'(NUM_SLOTS - 1);
      hnd_full_r <= !has_free;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
    else $error("read and write of one slot in the same cycle");

  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> space)
    else $error("result issued into a full output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && !adv |=> $stable(idx_r) && state_r == ST_SCAN)
    else $error("scan moved on while its result was stalled");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(next_free_r) <= NUM_SLOTS)
    else $error("free slot pointer beyond table");

endmodule

`default_nettype wire
